@@ src/rra_pkg.sv @@
// rra_pkg: shared types and constants of the ring region allocator
// no dependencies; used by rra_ctrl, rra_datapath and the top level
`default_nettype none

package rra_pkg;

  // slot counts, positions and thresholds
  localparam int unsigned W          = 11;
  // largest ring the index logic serves
  localparam int unsigned DEPTH      = 1024;
  localparam logic [W-1:0] DEPTH_W   = W'(DEPTH);
  localparam logic [W-1:0] RESET_SIZE = W'(1024);

  typedef enum logic [2:0] {
    ACT_PALLOC  = 3'd0,
    ACT_PCOMMIT = 3'd1,
    ACT_PWAIT   = 3'd2,
    ACT_PABORT  = 3'd3,
    ACT_CALLOC  = 3'd4,
    ACT_CCOMMIT = 3'd5,
    ACT_CWAIT   = 3'd6,
    ACT_CABORT  = 3'd7
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ src/rra_ctrl.sv @@
// rra_ctrl: controller fsm, capture one word then run its execute state
// depends on rra_pkg
`default_nettype none

module rra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output rra_pkg::ctrl_cmd_t      cmd
);
  import rra_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    busy        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        busy        = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/rra_datapath.sv @@
// rra_datapath: ring state registers, alloc/commit/wait logic, result registers
// depends on rra_pkg; driven by rra_ctrl commands
`default_nettype none

module rra_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rra_pkg::ctrl_cmd_t      cmd,
  input  wire logic [2:0]              in_action,
  input  wire logic [rra_pkg::W-1:0]   in_amount,
  input  wire logic                    cfg_we,
  input  wire logic [rra_pkg::W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic [rra_pkg::W-1:0]        out_offset,
  output logic [rra_pkg::W-1:0]        out_granted,
  output logic                         out_pending,
  output logic                         out_producer_signal,
  output logic                         out_consumer_signal,
  output logic [rra_pkg::W-1:0]        out_free_slots,
  output logic [rra_pkg::W-1:0]        out_filled_slots
);
  import rra_pkg::*;

  typedef struct packed {
    logic [W-1:0] off;
    logic [W-1:0] grant;
    logic [W-1:0] pos;
    logic [W-1:0] endp;
  } alloc_res_t;

  function automatic alloc_res_t do_alloc(input logic [W-1:0] pos,
                                          input logic [W-1:0] endp,
                                          input logic [W-1:0] avail,
                                          input logic [W-1:0] size,
                                          input logic [W-1:0] want);
    logic [W-1:0] cap;
    logic [W-1:0] npos;
    logic [W-1:0] nend;
    logic [W-1:0] cap2;
    logic [W:0]   sum;
    alloc_res_t   r;
    cap  = (endp >= pos) ? endp - pos : '0;
    npos = (pos >= size) ? '0 : pos;
    sum  = {1'b0, npos} + {1'b0, avail};
    nend = (sum > {1'b0, size}) ? size : sum[W-1:0];
    cap2 = (nend >= npos) ? nend - npos : '0;
    r.off  = pos;
    r.pos  = pos;
    r.endp = endp;
    if (want <= cap) begin
      r.grant = want;
    end else if (endp == size && cap != '0) begin
      r.grant = cap;
    end else begin
      // refresh the cached end, wrapping at the ring end
      r.off   = npos;
      r.pos   = npos;
      r.endp  = nend;
      r.grant = (want < cap2) ? want : cap2;
    end
    return r;
  endfunction

  logic [W-1:0] ring_size_r;
  logic [W-1:0] prod_pos_r, prod_end_r, cons_pos_r, cons_end_r;
  logic [W-1:0] fill_r, prod_wait_r, cons_wait_r;
  logic [W-1:0] prod_pos_nxt, prod_end_nxt, cons_pos_nxt, cons_end_nxt;
  logic [W-1:0] fill_nxt, prod_wait_nxt, cons_wait_nxt;

  logic [2:0]   action_r;
  logic [W-1:0] amount_r;

  logic         valid_r;
  logic [W-1:0] offset_r, granted_r, free_r, filled_r;
  logic         pending_r, psig_r, csig_r;
  logic [W-1:0] offset_nxt, granted_nxt;
  logic         pending_nxt, psig_nxt, csig_nxt;

  logic [W-1:0] size, fc, freec, amt_cl, n_p, n_c, cap_p, cap_c;
  alloc_res_t   pa, ca;

  always_comb begin
    size = ring_size_r;
    if (size == '0) begin
      size = W'(1);
    end else if (size > DEPTH_W) begin
      size = DEPTH_W;
    end
    fc     = (fill_r > size) ? size : fill_r;
    freec  = size - fc;
    amt_cl = (amount_r < size) ? amount_r : size;
    cap_p  = (prod_end_r >= prod_pos_r) ? prod_end_r - prod_pos_r : '0;
    cap_c  = (cons_end_r >= cons_pos_r) ? cons_end_r - cons_pos_r : '0;
    n_p    = (amount_r < cap_p) ? amount_r : cap_p;
    n_c    = (amount_r < cap_c) ? amount_r : cap_c;
    n_c    = (n_c < fc) ? n_c : fc;
    pa     = do_alloc(prod_pos_r, prod_end_r, freec, size, amount_r);
    ca     = do_alloc(cons_pos_r, cons_end_r, fc, size, amount_r);
  end

  always_comb begin
    logic [W:0] fsum;
    fsum          = {1'b0, fc} + {1'b0, n_p};
    prod_pos_nxt  = prod_pos_r;
    prod_end_nxt  = prod_end_r;
    cons_pos_nxt  = cons_pos_r;
    cons_end_nxt  = cons_end_r;
    fill_nxt      = fc;
    prod_wait_nxt = prod_wait_r;
    cons_wait_nxt = cons_wait_r;
    offset_nxt    = '0;
    granted_nxt   = '0;
    pending_nxt   = 1'b0;
    psig_nxt      = 1'b0;
    csig_nxt      = 1'b0;
    case (action_t'(action_r))
      ACT_PALLOC: begin
        prod_pos_nxt = pa.pos;
        prod_end_nxt = pa.endp;
        offset_nxt   = pa.off;
        granted_nxt  = pa.grant;
      end
      ACT_PCOMMIT: begin
        prod_pos_nxt = prod_pos_r + n_p;
        fill_nxt     = (fsum > {1'b0, size}) ? size : fsum[W-1:0];
        offset_nxt   = prod_pos_nxt;
        if (cons_wait_r != '0 && cons_wait_r <= fill_nxt) begin
          csig_nxt      = 1'b1;
          cons_wait_nxt = '0;
        end
      end
      ACT_PWAIT: begin
        pending_nxt   = amt_cl > freec;
        prod_wait_nxt = pending_nxt ? amt_cl : '0;
      end
      ACT_PABORT: begin
        pending_nxt   = prod_wait_r != '0;
        prod_wait_nxt = '0;
      end
      ACT_CALLOC: begin
        cons_pos_nxt = ca.pos;
        cons_end_nxt = ca.endp;
        offset_nxt   = ca.off;
        granted_nxt  = ca.grant;
      end
      ACT_CCOMMIT: begin
        cons_pos_nxt = cons_pos_r + n_c;
        fill_nxt     = fc - n_c;
        offset_nxt   = cons_pos_nxt;
        if (prod_wait_r != '0 && prod_wait_r <= size - fill_nxt) begin
          psig_nxt      = 1'b1;
          prod_wait_nxt = '0;
        end
      end
      ACT_CWAIT: begin
        pending_nxt   = amt_cl > fc;
        cons_wait_nxt = pending_nxt ? amt_cl : '0;
      end
      ACT_CABORT: begin
        pending_nxt   = cons_wait_r != '0;
        cons_wait_nxt = '0;
      end
      default: begin
        pending_nxt = 1'b0;
      end
    endcase
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      amount_r <= in_amount;
    end
  end

  // ring state; a size write starts a fresh ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RESET_SIZE;
      prod_pos_r  <= '0;
      prod_end_r  <= '0;
      cons_pos_r  <= '0;
      cons_end_r  <= '0;
      fill_r      <= '0;
      prod_wait_r <= '0;
      cons_wait_r <= '0;
    end else if (cfg_we) begin
      ring_size_r <= cfg_wdata;
      prod_pos_r  <= '0;
      prod_end_r  <= '0;
      cons_pos_r  <= '0;
      cons_end_r  <= '0;
      fill_r      <= '0;
      prod_wait_r <= '0;
      cons_wait_r <= '0;
    end else if (cmd.execute) begin
      prod_pos_r  <= prod_pos_nxt;
      prod_end_r  <= prod_end_nxt;
      cons_pos_r  <= cons_pos_nxt;
      cons_end_r  <= cons_end_nxt;
      fill_r      <= fill_nxt;
      prod_wait_r <= prod_wait_nxt;
      cons_wait_r <= cons_wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      offset_r  <= offset_nxt;
      granted_r <= granted_nxt;
      pending_r <= pending_nxt;
      psig_r    <= psig_nxt;
      csig_r    <= csig_nxt;
      free_r    <= size - fill_nxt;
      filled_r  <= fill_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_offset          = offset_r;
  assign out_granted         = granted_r;
  assign out_pending         = pending_r;
  assign out_producer_signal = psig_r;
  assign out_consumer_signal = csig_r;
  assign out_free_slots      = free_r;
  assign out_filled_slots    = filled_r;

endmodule

`default_nettype wire

@@ src/ring_region_allocator_top.sv @@
// ring_region_allocator_top: index controller of a single-producer,
// single-consumer ring; instantiates rra_ctrl and rra_datapath, uses rra_pkg
`default_nettype none

// A word is taken at a clock edge with start high and busy low. The
// controller then enters its execute state, in which busy is high and the
// datapath updates the ring state, and the result appears on the out_
// ports for exactly one cycle with out_valid high, starting right after
// the execute cycle. busy is already low in that result cycle, so the
// next word can be taken there. No word is taken in the execute state,
// which the controller enters after every capture. The receiver cannot
// stall, a result must be taken in the cycle it is shown. Writing
// cfg_wdata with cfg_we high sets the ring size and restarts the ring
// (positions, fill count and waits cleared); write it only while idle.
module ring_region_allocator_top (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // command side
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              in_action,
  input  wire logic [rra_pkg::W-1:0]   in_amount,
  // ring size register
  input  wire logic                    cfg_we,
  input  wire logic [rra_pkg::W-1:0]   cfg_wdata,
  // result side, one-cycle strobe
  output logic                         out_valid,
  output logic [rra_pkg::W-1:0]        out_offset,
  output logic [rra_pkg::W-1:0]        out_granted,
  output logic                         out_pending,
  output logic                         out_producer_signal,
  output logic                         out_consumer_signal,
  output logic [rra_pkg::W-1:0]        out_free_slots,
  output logic [rra_pkg::W-1:0]        out_filled_slots
);
  import rra_pkg::*;

  ctrl_cmd_t cmd;

  // sequencing: idle -> execute -> idle
  rra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // ring state, allocation and wait logic, result registers
  rra_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_action           (in_action),
    .in_amount           (in_amount),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_offset          (out_offset),
    .out_granted         (out_granted),
    .out_pending         (out_pending),
    .out_producer_signal (out_producer_signal),
    .out_consumer_signal (out_consumer_signal),
    .out_free_slots      (out_free_slots),
    .out_filled_slots    (out_filled_slots)
  );

  // an accepted word runs its execute cycle next, no stale strobe there
  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted word did not enter execute");

  // every execute cycle yields exactly one result strobe
  a_exec_result : assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("execute cycle without result");

  // free and filled slots together never exceed the largest ring
  a_slot_sum : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_free_slots} + {1'b0, out_filled_slots})
                  <= {1'b0, DEPTH_W})
    else $error("free plus filled slots out of range");

  // capture and execute commands never overlap
  a_cmd_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute at once");

endmodule

`default_nettype wire
